FILE: rtl/core/gdg_pkg.sv
// shared types and constants of the gaze drift grid correction block
package gdg_pkg;

    localparam int GRID_COLS     = 8;
    localparam int GRID_ROWS     = 8;
    localparam int NEAREST_COUNT = 9;
    localparam int CELL_COUNT    = GRID_COLS * GRID_ROWS;

    localparam int CW   = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int COLW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROWW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int KW   = (NEAREST_COUNT > 1) ? $clog2(NEAREST_COUNT) : 1;

    localparam int XW  = 16;
    localparam int WW  = 12;
    localparam int DRW = 17;
    localparam int OW  = 18;

    localparam longint XS    = 2 * GRID_COLS * GRID_ROWS;
    localparam longint CXS   = 16 * GRID_ROWS;
    localparam longint CYS   = 16 * GRID_COLS;
    localparam longint PMAX  = 65535 * XS;
    localparam longint OXMAX = (2 * GRID_COLS - 1) * 4095 * CXS;
    localparam longint OYMAX = (2 * GRID_ROWS - 1) * 4095 * CYS;
    localparam longint AMAX0 = (PMAX > OXMAX) ? PMAX : OXMAX;
    localparam longint AMAX  = (AMAX0 > OYMAX) ? AMAX0 : OYMAX;
    localparam int     AW    = $clog2(AMAX + 1);
    localparam int     DW    = 2 * AW + 1;
    localparam int     SQW   = DW + (DW % 2);
    localparam int     SW    = SQW / 2;
    localparam int     SQCW  = $clog2(SW + 1);

    localparam int     IMAXC = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
    localparam longint IAMAX = 65535 * IMAXC + 65520 * IMAXC;
    localparam int     IAW   = $clog2(IAMAX + 1);
    localparam int     ISTEPS = IMAXC - 1;
    localparam int     ICW   = (ISTEPS > 0) ? $clog2(ISTEPS + 1) : 1;

    localparam int RW    = 17;
    localparam int QW    = 18;
    localparam int DENW  = $clog2(NEAREST_COUNT * 65536 + 1);
    localparam int PRODW = RW + 1 + DRW;
    localparam int NUMW  = PRODW + ((NEAREST_COUNT > 1) ? $clog2(NEAREST_COUNT) : 1);
    localparam int DVW0  = (SW > DENW) ? SW : DENW;
    localparam int DVW   = (DVW0 > NUMW - QW) ? DVW0 : NUMW - QW;
    localparam int DCW   = $clog2(QW + 1);

    localparam int QDEPTH = 2;
    localparam int QPW    = 1;

    localparam int CFGIW = 2;
    localparam logic [CFGIW-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFGIW-1:0] REG_HEIGHT = 2'd1;
    localparam logic [WW-1:0] WIDTH_RESET  = 12'd1280;
    localparam logic [WW-1:0] HEIGHT_RESET = 12'd720;

    typedef enum logic [1:0] {
        CMD_GAZE  = 2'd0,
        CMD_INTER = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_APPLY = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd          cmd;
        logic [XW-1:0] x;
        logic [XW-1:0] y;
    } t_item;

endpackage

FILE: rtl/core/gdg_front.sv
// front stage: takes input transfers, classifies the command, hands items to the queue
module gdg_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_command,
    input  logic [gdg_pkg::XW-1:0]    i_coord_x,
    input  logic [gdg_pkg::XW-1:0]    i_coord_y,
    output logic                      o_push_valid,
    output gdg_pkg::t_item            o_push_item,
    input  logic                      i_push_ready
);

    logic           r_vld;
    gdg_pkg::t_item r_item;
    gdg_pkg::t_cmd  cmd_dec;

    assign cmd_dec      = gdg_pkg::t_cmd'(i_command);
    assign o_ready      = !r_vld || i_push_ready;
    assign o_push_valid = r_vld;
    assign o_push_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_vld      <= 1'b1;
                r_item.cmd <= cmd_dec;
                r_item.x   <= i_coord_x;
                r_item.y   <= i_coord_y;
            end else if (i_push_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/gdg_queue.sv
// two-entry queue between the front stage and the sequencer
module gdg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  gdg_pkg::t_item i_push_item,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output gdg_pkg::t_item o_pop_item,
    input  logic           i_pop_ready
);

    gdg_pkg::t_item                r_mem [gdg_pkg::QDEPTH];
    logic [gdg_pkg::QPW-1:0]       r_wp;
    logic [gdg_pkg::QPW-1:0]       r_rp;
    logic [gdg_pkg::QPW:0]         r_cnt;
    logic                          push;
    logic                          pop;

    assign o_push_ready = (r_cnt < (gdg_pkg::QPW+1)'(gdg_pkg::QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (gdg_pkg::QPW+1)'(push) - (gdg_pkg::QPW+1)'(pop);
        end
    end

endmodule

FILE: rtl/core/gdg_back.sv
// sequencer: grid store, nearest-cell scan, root and divide unit, weighted mean
module gdg_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [gdg_pkg::WW-1:0]         i_width,
    input  logic [gdg_pkg::WW-1:0]         i_height,
    input  logic                           i_item_valid,
    input  gdg_pkg::t_item                 i_item,
    output logic                           o_item_ready,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [gdg_pkg::OW-1:0]  o_corrected_x,
    output logic signed [gdg_pkg::OW-1:0]  o_corrected_y
);

    localparam int AW   = gdg_pkg::AW;
    localparam int DW   = gdg_pkg::DW;
    localparam int SW   = gdg_pkg::SW;
    localparam int SQW  = gdg_pkg::SQW;
    localparam int NC   = gdg_pkg::NEAREST_COUNT;
    localparam int CW   = gdg_pkg::CW;
    localparam int RW   = gdg_pkg::RW;
    localparam int QW   = gdg_pkg::QW;
    localparam int DVW  = gdg_pkg::DVW;
    localparam int NUMW = gdg_pkg::NUMW;
    localparam int DENW = gdg_pkg::DENW;
    localparam int IAW  = gdg_pkg::IAW;
    localparam int DRW  = gdg_pkg::DRW;
    localparam int OW   = gdg_pkg::OW;
    localparam int KW_T = gdg_pkg::KW;

    typedef enum logic [3:0] {
        S_IDLE, S_IDX, S_IWR, S_SCAN, S_HIT, S_SQLD, S_SQRT, S_RDLD,
        S_DIV, S_MUL1, S_MUL2, S_ACC, S_MNLD, S_MNFIN, S_OUT
    } t_state;

    t_state r_state;

    // item and gaze
    logic [gdg_pkg::XW-1:0] r_px, r_py, r_gx, r_gy;

    // drift store
    logic [2*DRW-1:0]          r_mem [gdg_pkg::CELL_COUNT];
    logic [gdg_pkg::CELL_COUNT-1:0] r_vld;
    logic [2*DRW-1:0]          r_rd;
    logic                      r_rd_vld;
    logic [CW-1:0]             rd_addr;
    logic                      mem_we;
    logic [CW-1:0]             wr_addr;
    logic [2*DRW-1:0]          wr_data;

    // cell index search
    logic [gdg_pkg::COLW-1:0] r_ix;
    logic [gdg_pkg::ROWW-1:0] r_iy;
    logic [IAW-1:0]           r_accx, r_accy;
    logic [gdg_pkg::ICW-1:0]  r_icnt;

    // scan pipeline
    logic                     r_run, r_a_vld, r_b_vld;
    logic [gdg_pkg::COLW-1:0] r_cx;
    logic [gdg_pkg::ROWW-1:0] r_cy;
    logic [CW-1:0]            r_cidx, r_a_idx, r_b_idx;
    logic [AW-1:0]            r_offx, r_offy, r_ax, r_ay;
    logic [DW-1:0]            r_b_d2;
    logic [DW-1:0]            r_ld2  [NC];
    logic [CW-1:0]            r_lidx [NC];
    logic [NC-1:0]            lt;

    // root, divide, accumulate
    logic [KW_T-1:0]          r_k;
    logic [SQW-1:0]           r_sq_v;
    logic [SW+1:0]            r_sq_rem;
    logic [SW-1:0]            r_root, r_d, r_d0;
    logic [gdg_pkg::SQCW-1:0] r_sq_cnt;
    logic [DVW-1:0]           r_dv_rem, r_dv_den;
    logic [QW-1:0]            r_dv_lo, r_dv_q;
    logic [gdg_pkg::DCW-1:0]  r_dv_cnt;
    logic                     r_mean, r_ydir, r_neg;
    logic [RW-1:0]            r_rr, r_w;
    logic signed [NUMW-1:0]   r_numx, r_numy;
    logic [DENW-1:0]          r_den;
    logic signed [OW-1:0]     r_drx, r_dry;
    logic                     r_ovld;
    logic signed [OW-1:0]     r_ox, r_oy;

    // scan arithmetic
    logic [AW-1:0]          pxs, pys, stepx, stepy, basex, basey;
    logic signed [AW:0]     ddx, ddy;
    logic [AW-1:0]          ax, ay;
    logic [2*AW-1:0]        sqx, sqy;

    assign pxs   = AW'(r_px) * AW'(gdg_pkg::XS);
    assign pys   = AW'(r_py) * AW'(gdg_pkg::XS);
    assign basex = AW'(i_width) * AW'(gdg_pkg::CXS);
    assign basey = AW'(i_height) * AW'(gdg_pkg::CYS);
    assign stepx = AW'(i_width) * AW'(2 * gdg_pkg::CXS);
    assign stepy = AW'(i_height) * AW'(2 * gdg_pkg::CYS);
    assign ddx   = $signed({1'b0, pxs}) - $signed({1'b0, r_offx});
    assign ddy   = $signed({1'b0, pys}) - $signed({1'b0, r_offy});
    assign ax    = ddx[AW] ? AW'(-ddx) : ddx[AW-1:0];
    assign ay    = ddy[AW] ? AW'(-ddy) : ddy[AW-1:0];
    assign sqx   = r_ax * r_ax;
    assign sqy   = r_ay * r_ay;

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            lt[k] = (r_b_d2 < r_ld2[k]);
        end
    end

    // root step
    logic [SW+3:0] sq_r2, sq_trial;
    logic          sq_ge;
    assign sq_r2    = {r_sq_rem, r_sq_v[SQW-1 -: 2]};
    assign sq_trial = (SW+4)'({r_root, 2'b01});
    assign sq_ge    = (sq_r2 >= sq_trial);

    // divide step
    logic [DVW:0] dv_t;
    logic         dv_ge;
    assign dv_t  = {r_dv_rem, r_dv_lo[QW-1]};
    assign dv_ge = (dv_t >= {1'b0, r_dv_den});

    // weights and mean
    logic [2*RW-1:0]         p1, p2;
    logic signed [DRW-1:0]   dvx, dvy;
    logic signed [gdg_pkg::PRODW-1:0] wx, wy;
    logic signed [NUMW-1:0]  numsel;
    logic [NUMW-1:0]         mag, numer;
    logic signed [OW-1:0]    qs;
    logic [gdg_pkg::IAW-1:0] gxs, gys;

    assign p1     = r_dv_q[RW-1:0] * r_dv_q[RW-1:0];
    assign p2     = r_rr * r_dv_q[RW-1:0];
    assign dvx    = r_rd_vld ? $signed(r_rd[2*DRW-1:DRW]) : '0;
    assign dvy    = r_rd_vld ? $signed(r_rd[DRW-1:0]) : '0;
    assign wx     = $signed({1'b0, r_w}) * dvx;
    assign wy     = $signed({1'b0, r_w}) * dvy;
    assign numsel = r_ydir ? r_numy : r_numx;
    assign mag    = numsel[NUMW-1] ? NUMW'(-numsel) : NUMW'(numsel);
    assign numer  = mag + NUMW'(r_den >> 1);
    assign qs     = r_neg ? -$signed(r_dv_q) : $signed(r_dv_q);
    assign gxs    = IAW'(r_gx) * IAW'(gdg_pkg::GRID_COLS);
    assign gys    = IAW'(r_gy) * IAW'(gdg_pkg::GRID_ROWS);

    assign rd_addr = r_lidx[r_k];
    assign mem_we  = (r_state == S_IWR);
    assign wr_addr = CW'(r_ix * gdg_pkg::GRID_ROWS) + CW'(r_iy);
    assign wr_data = {DRW'({1'b0, r_gx}) - DRW'({1'b0, r_px}),
                      DRW'({1'b0, r_gy}) - DRW'({1'b0, r_py})};

    assign o_item_ready  = (r_state == S_IDLE);
    assign o_valid       = r_ovld;
    assign o_corrected_x = r_ox;
    assign o_corrected_y = r_oy;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd     <= r_mem[rd_addr];
        r_rd_vld <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gx    <= '0;
            r_gy    <= '0;
            r_vld   <= '0;
            r_run   <= 1'b0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_ovld  <= 1'b0;
            r_k     <= '0;
        end else begin
            if (i_ready && r_state != S_OUT) begin
                r_ovld <= 1'b0;
            end

            // scan pipeline, runs whenever fed
            r_a_vld <= r_run;
            r_b_vld <= r_a_vld;
            r_ax    <= ax;
            r_ay    <= ay;
            r_a_idx <= r_cidx;
            r_b_d2  <= DW'(sqx) + DW'(sqy);
            r_b_idx <= r_a_idx;
            if (r_b_vld) begin
                if (lt[0]) begin
                    r_ld2[0]  <= r_b_d2;
                    r_lidx[0] <= r_b_idx;
                end
                for (int k = 1; k < NC; k++) begin
                    if (lt[k-1]) begin
                        r_ld2[k]  <= r_ld2[k-1];
                        r_lidx[k] <= r_lidx[k-1];
                    end else if (lt[k]) begin
                        r_ld2[k]  <= r_b_d2;
                        r_lidx[k] <= r_b_idx;
                    end
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_px <= i_item.x;
                        r_py <= i_item.y;
                        unique case (i_item.cmd)
                            gdg_pkg::CMD_GAZE: begin
                                r_gx <= i_item.x;
                                r_gy <= i_item.y;
                            end
                            gdg_pkg::CMD_INTER: begin
                                r_ix    <= '0;
                                r_iy    <= '0;
                                r_accx  <= IAW'({i_width, 4'b0});
                                r_accy  <= IAW'({i_height, 4'b0});
                                r_icnt  <= gdg_pkg::ICW'(gdg_pkg::ISTEPS);
                                r_state <= S_IDX;
                            end
                            gdg_pkg::CMD_CLEAR: begin
                                r_vld <= '0;
                            end
                            default: begin
                                r_run  <= 1'b1;
                                r_cx   <= '0;
                                r_cy   <= '0;
                                r_cidx <= '0;
                                r_offx <= basex;
                                r_offy <= basey;
                                r_k    <= '0;
                                r_numx <= '0;
                                r_numy <= '0;
                                r_den  <= '0;
                                for (int k = 0; k < NC; k++) begin
                                    r_ld2[k] <= '1;
                                end
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_IDX: begin
                    if (r_ix < gdg_pkg::COLW'(gdg_pkg::GRID_COLS - 1) && r_accx <= gxs) begin
                        r_ix   <= r_ix + 1'b1;
                        r_accx <= r_accx + IAW'({i_width, 4'b0});
                    end
                    if (r_iy < gdg_pkg::ROWW'(gdg_pkg::GRID_ROWS - 1) && r_accy <= gys) begin
                        r_iy   <= r_iy + 1'b1;
                        r_accy <= r_accy + IAW'({i_height, 4'b0});
                    end
                    r_icnt <= r_icnt - 1'b1;
                    if (r_icnt <= gdg_pkg::ICW'(1)) begin
                        r_state <= S_IWR;
                    end
                end
                S_IWR: begin
                    r_vld[wr_addr] <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_run) begin
                        r_cidx <= r_cidx + 1'b1;
                        if (r_cy == gdg_pkg::ROWW'(gdg_pkg::GRID_ROWS - 1)) begin
                            r_cy   <= '0;
                            r_offy <= basey;
                            if (r_cx == gdg_pkg::COLW'(gdg_pkg::GRID_COLS - 1)) begin
                                r_run <= 1'b0;
                            end else begin
                                r_cx   <= r_cx + 1'b1;
                                r_offx <= r_offx + stepx;
                            end
                        end else begin
                            r_cy   <= r_cy + 1'b1;
                            r_offy <= r_offy + stepy;
                        end
                    end else if (!r_a_vld && !r_b_vld) begin
                        r_state <= (r_ld2[0] == '0) ? S_HIT : S_SQLD;
                    end
                end
                S_HIT: begin
                    r_drx   <= OW'(dvx);
                    r_dry   <= OW'(dvy);
                    r_state <= S_OUT;
                end
                S_SQLD: begin
                    r_sq_v   <= SQW'(r_ld2[r_k]);
                    r_sq_rem <= '0;
                    r_root   <= '0;
                    r_sq_cnt <= gdg_pkg::SQCW'(SW);
                    r_state  <= S_SQRT;
                end
                S_SQRT: begin
                    r_sq_v   <= r_sq_v << 2;
                    r_sq_rem <= sq_ge ? (SW+2)'(sq_r2 - sq_trial) : (SW+2)'(sq_r2);
                    r_root   <= {r_root[SW-2:0], sq_ge};
                    r_sq_cnt <= r_sq_cnt - 1'b1;
                    if (r_sq_cnt == gdg_pkg::SQCW'(1)) begin
                        r_d <= {r_root[SW-2:0], sq_ge};
                        if (r_k == '0) begin
                            r_d0 <= {r_root[SW-2:0], sq_ge};
                        end
                        r_state <= S_RDLD;
                    end
                end
                S_RDLD: begin
                    r_dv_den <= DVW'(r_d);
                    r_dv_rem <= DVW'(r_d0 >> 1);
                    r_dv_lo  <= {r_d0[0], {(QW-1){1'b0}}};
                    r_dv_q   <= '0;
                    r_dv_cnt <= gdg_pkg::DCW'(RW);
                    r_mean   <= 1'b0;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    r_dv_rem <= dv_ge ? DVW'(dv_t - {1'b0, r_dv_den}) : DVW'(dv_t);
                    r_dv_lo  <= r_dv_lo << 1;
                    r_dv_q   <= {r_dv_q[QW-2:0], dv_ge};
                    r_dv_cnt <= r_dv_cnt - 1'b1;
                    if (r_dv_cnt == gdg_pkg::DCW'(1)) begin
                        r_state <= r_mean ? S_MNFIN : S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_rr    <= p1[RW+15:16];
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_w     <= p2[RW+15:16];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_numx <= r_numx + NUMW'(wx);
                    r_numy <= r_numy + NUMW'(wy);
                    r_den  <= r_den + DENW'(r_w);
                    if (r_k == KW_T'(NC - 1)) begin
                        r_ydir  <= 1'b0;
                        r_state <= S_MNLD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SQLD;
                    end
                end
                S_MNLD: begin
                    r_neg    <= numsel[NUMW-1];
                    r_dv_den <= DVW'(r_den);
                    r_dv_rem <= DVW'(numer[NUMW-1:QW]);
                    r_dv_lo  <= numer[QW-1:0];
                    r_dv_q   <= '0;
                    r_dv_cnt <= gdg_pkg::DCW'(QW);
                    r_mean   <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_MNFIN: begin
                    if (r_ydir) begin
                        r_dry   <= qs;
                        r_state <= S_OUT;
                    end else begin
                        r_drx   <= qs;
                        r_ydir  <= 1'b1;
                        r_state <= S_MNLD;
                    end
                end
                S_OUT: begin
                    if (!r_ovld || i_ready) begin
                        r_ovld  <= 1'b1;
                        r_ox    <= $signed({2'b0, r_px}) - r_drx;
                        r_oy    <= $signed({2'b0, r_py}) - r_dry;
                        r_state <= S_IDLE;
                        r_k     <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> (!r_run && !r_a_vld && !r_b_vld))
        else $error("scan pipeline active outside scan");

    a_pick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k < KW_T'(NC))
        else $error("nearest pick counter out of range");

    a_out_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_ovld || i_ready)) |=> (r_ovld && r_state == S_IDLE))
        else $error("result not loaded into output register");

endmodule

FILE: rtl/core/gaze_drift_grid_idw_correct.sv
// top level: configuration registers, front stage, queue and sequencer
// an apply scans every cell of the grid, then for each of the nearest cells
//   runs the root, the divide, the weight and the fetch, then the two
//   mean divides, one apply at a time; an exact centre hit skips the weighting
// gaze and clear are taken in the idle state, interaction runs the cell index search
// the front stage and queue take new transfers while the sequencer is busy, until both are full
// synchronous active-low reset: window 1280 x 720, gaze zero, grid all zero
module gaze_drift_grid_idw_correct (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_command,
    input  logic [gdg_pkg::XW-1:0]              i_coord_x,
    input  logic [gdg_pkg::XW-1:0]              i_coord_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [gdg_pkg::OW-1:0]       o_corrected_x,
    output logic signed [gdg_pkg::OW-1:0]       o_corrected_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gdg_pkg::CFGIW-1:0]           i_cfg_index,
    input  logic [gdg_pkg::WW-1:0]              i_cfg_data
);

    logic [gdg_pkg::WW-1:0] r_width;
    logic [gdg_pkg::WW-1:0] r_height;

    logic           push_valid, push_ready, pop_valid, pop_ready;
    gdg_pkg::t_item push_item, pop_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= gdg_pkg::WIDTH_RESET;
            r_height <= gdg_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gdg_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                gdg_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gdg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    gdg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    gdg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_width       (r_width),
        .i_height      (r_height),
        .i_item_valid  (pop_valid),
        .i_item        (pop_item),
        .o_item_ready  (pop_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_corrected_x (o_corrected_x),
        .o_corrected_y (o_corrected_y)
    );

endmodule

FILE: verif/gaze_drift_grid_idw_correct_tb.sv
// self-checking testbench of the gaze drift grid correction block
module gaze_drift_grid_idw_correct_tb;
    import gdg_pkg::*;

    typedef struct {
        t_cmd          cmd;
        logic [XW-1:0] x;
        logic [XW-1:0] y;
    } t_req;

    typedef struct {
        logic signed [OW-1:0] cx;
        logic signed [OW-1:0] cy;
    } t_corr;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_command = '0;
    logic [XW-1:0] i_coord_x = '0;
    logic [XW-1:0] i_coord_y = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [OW-1:0] o_corrected_x;
    logic signed [OW-1:0] o_corrected_y;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFGIW-1:0] i_cfg_index = '0;
    logic [WW-1:0] i_cfg_data = '0;

    gaze_drift_grid_idw_correct u_top (.*);

    // predictor state
    logic [WW-1:0] win_w, win_h;
    logic [XW-1:0] gaze_x, gaze_y;
    logic signed [DRW-1:0] grid_dx [CELL_COUNT];
    logic signed [DRW-1:0] grid_dy [CELL_COUNT];

    t_req  pending_reqs[$];
    t_corr corr_expected[$];
    int    mismatches = 0;
    int    applies_seen = 0;
    int    reqs_sent = 0;
    bit    driver_on = 1'b0;
    int    send_gap = 0;
    int    recv_gap = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic int unsigned cell_of(logic [XW-1:0] g, logic [WW-1:0] sz, int n);
        longint unsigned idx;
        if (sz == 0) return n - 1;
        idx = (longint'(g) * n) / (longint'(sz) * 16);
        if (idx > n - 1) idx = n - 1;
        return int'(idx);
    endfunction

    function automatic longint round_mean(longint wt[NEAREST_COUNT], longint v[NEAREST_COUNT],
                                          int n);
        longint num, den;
        longint unsigned mag, q;
        num = 0;
        den = 0;
        for (int i = 0; i < n; i++) begin
            num += wt[i] * v[i];
            den += wt[i];
        end
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    task automatic predict_correction(t_req r);
        longint unsigned d2 [CELL_COUNT];
        bit used [CELL_COUNT];
        int pick [NEAREST_COUNT];
        longint wt [NEAREST_COUNT], vx [NEAREST_COUNT], vy [NEAREST_COUNT];
        longint ddx, ddy, drx, dry;
        longint unsigned d0, d, rq;
        int n, best;
        t_corr c;
        int ix, iy;
        case (r.cmd)
            CMD_GAZE: begin
                gaze_x = r.x;
                gaze_y = r.y;
            end
            CMD_INTER: begin
                ix = cell_of(gaze_x, win_w, GRID_COLS);
                iy = cell_of(gaze_y, win_h, GRID_ROWS);
                grid_dx[ix*GRID_ROWS+iy] = DRW'(longint'(gaze_x) - longint'(r.x));
                grid_dy[ix*GRID_ROWS+iy] = DRW'(longint'(gaze_y) - longint'(r.y));
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++) begin
                    grid_dx[i] = '0;
                    grid_dy[i] = '0;
                end
            end
            default: begin
                for (int cx = 0; cx < GRID_COLS; cx++)
                    for (int cy = 0; cy < GRID_ROWS; cy++) begin
                        ddx = longint'(r.x) * (2*GRID_COLS*GRID_ROWS)
                            - longint'(2*cx+1) * longint'(win_w) * (16*GRID_ROWS);
                        ddy = longint'(r.y) * (2*GRID_COLS*GRID_ROWS)
                            - longint'(2*cy+1) * longint'(win_h) * (16*GRID_COLS);
                        if (ddx < 0) ddx = -ddx;
                        if (ddy < 0) ddy = -ddy;
                        d2[cx*GRID_ROWS+cy] = ddx*ddx + ddy*ddy;
                        used[cx*GRID_ROWS+cy] = 1'b0;
                    end
                n = NEAREST_COUNT < CELL_COUNT ? NEAREST_COUNT : CELL_COUNT;
                for (int k = 0; k < n; k++) begin
                    best = -1;
                    for (int i = 0; i < CELL_COUNT; i++)
                        if (!used[i] && (best < 0 || d2[i] < d2[best])) best = i;
                    used[best] = 1'b1;
                    pick[k] = best;
                end
                if (d2[pick[0]] == 0) begin
                    drx = grid_dx[pick[0]];
                    dry = grid_dy[pick[0]];
                end else begin
                    d0 = int_sqrt(d2[pick[0]]);
                    for (int k = 0; k < n; k++) begin
                        d = int_sqrt(d2[pick[k]]);
                        rq = (d0 << 16) / d;
                        wt[k] = longint'((((rq*rq) >> 16) * rq) >> 16);
                        vx[k] = grid_dx[pick[k]];
                        vy[k] = grid_dy[pick[k]];
                    end
                    drx = round_mean(wt, vx, n);
                    dry = round_mean(wt, vy, n);
                end
                c.cx = OW'(longint'(r.x) - drx);
                c.cy = OW'(longint'(r.y) - dry);
                corr_expected.insert(corr_expected.size(), c);
            end
        endcase
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            predict_correction(pending_reqs.pop_front());
            reqs_sent++;
        end
        if (!i_valid || o_ready) begin
            if (driver_on && pending_reqs.size() > 0 &&
                !(i_valid && o_ready && pending_reqs.size() == 0)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else begin
                    i_valid   <= 1'b1;
                    i_command <= pending_reqs[0].cmd;
                    i_coord_x <= pending_reqs[0].x;
                    i_coord_y <= pending_reqs[0].y;
                    send_gap  <= pick_gap();
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_corr e;
        if (o_valid && i_ready) begin
            applies_seen++;
            if (corr_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d", o_corrected_x, o_corrected_y);
            end else begin
                e = corr_expected.pop_front();
                if (e.cx !== o_corrected_x || e.cy !== o_corrected_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                 e.cx, e.cy, o_corrected_x, o_corrected_y);
                end
            end
        end
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
        end
    end

    task automatic push_req(t_cmd c, int x, int y);
        t_req r;
        r.cmd = c;
        r.x = XW'(x);
        r.y = XW'(y);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_valid || corr_expected.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFGIW-1:0] idx, logic [WW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_WIDTH) win_w = val;
        else if (idx == REG_HEIGHT) win_h = val;
        i_cfg_valid <= 1'b0;
    endtask

    // random mix: mostly corrections, with gaze and interaction pairs, lone commands and clears
    task automatic random_phase(int count, int xmax);
        int p;
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(0, 99);
            if (p < 35) begin
                push_req(CMD_GAZE, $urandom_range(0, xmax), $urandom_range(0, xmax));
                push_req(CMD_INTER, $urandom_range(0, xmax), $urandom_range(0, xmax));
                i++;
            end else if (p < 40) begin
                push_req(CMD_INTER, $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else if (p < 42) begin
                push_req(CMD_CLEAR, $urandom, $urandom);
            end else if (p < 47) begin
                push_req(CMD_GAZE, $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else begin
                push_req(CMD_APPLY, $urandom_range(0, xmax), $urandom_range(0, xmax));
            end
        end
    endtask

    initial begin
        win_w = WIDTH_RESET;
        win_h = HEIGHT_RESET;
        gaze_x = '0;
        gaze_y = '0;
        for (int i = 0; i < CELL_COUNT; i++) begin
            grid_dx[i] = '0;
            grid_dy[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: edges, clamping, exact centre hit, clear
        push_req(CMD_APPLY, 0, 0);
        push_req(CMD_GAZE, 16'hFFFF, 16'hFFFF);
        push_req(CMD_INTER, 0, 0);
        push_req(CMD_APPLY, 16'hFFFF, 16'hFFFF);
        push_req(CMD_GAZE, 0, 0);
        push_req(CMD_INTER, 16'hFFFF, 16'hFFFF);
        push_req(CMD_GAZE, 80*16, 45*16);
        push_req(CMD_INTER, 100*16, 30*16);
        push_req(CMD_APPLY, 80*16, 45*16);
        push_req(CMD_APPLY, 0, 0);
        push_req(CMD_APPLY, 640*16, 360*16);
        push_req(CMD_APPLY, 16'hFFFF, 0);
        push_req(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        push_req(CMD_APPLY, 80*16, 45*16);
        driver_on = 1'b1;
        wait_drained();

        write_reg(REG_WIDTH, 12'd4095);
        write_reg(REG_HEIGHT, 12'd1);
        random_phase(250, 65535);
        wait_drained();

        write_reg(REG_WIDTH, 12'd0);
        write_reg(REG_HEIGHT, 12'd0);
        push_req(CMD_GAZE, 5, 5);
        push_req(CMD_INTER, 0, 9);
        push_req(CMD_APPLY, 0, 0);
        random_phase(100, 65535);
        wait_drained();

        write_reg(REG_WIDTH, 12'd1);
        write_reg(REG_HEIGHT, 12'd4095);
        random_phase(200, 65535);
        wait_drained();

        write_reg(REG_WIDTH, 12'd1920);
        write_reg(REG_HEIGHT, 12'd1080);
        write_reg(2'd3, 12'hABC);
        random_phase(450, 1920*16);
        wait_drained();

        $display("%0d commands sent, %0d corrections checked over five window settings",
                 reqs_sent, applies_seen);
        if (mismatches == 0 && corr_expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #60000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
